[sv/cmap4_pkg.sv]
// Shared types and constants for the cmap format 4 glyph lookup unit.
// Depends on nothing; every other file of the block but cmap4_ram imports it.
package cmap4_pkg;

    // Sizes of the subtable stores.
    localparam int MAX_SEGMENTS = 64;
    localparam int GLYPH_ARRAY_DEPTH = 1024;

    // Field widths.
    localparam int WORD_W = 16;
    localparam int CMD_W = 2;
    localparam int SLOT_W = 10;
    localparam int SEG_CNT_W = 7;
    localparam int SEG_ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int GLYPH_ADDR_W = $clog2(GLYPH_ARRAY_DEPTH);
    localparam int SEG_RAM_W = 4 * WORD_W;

    // Signed width of the glyph array position, wide enough for
    // range/2 + (code - start) minus the segment distance.
    localparam int POS_W = WORD_W + 2;

    // Segment count after reset.
    localparam logic [SEG_CNT_W-1:0] SEG_CNT_RESET = SEG_CNT_W'(1);

    // Command codes of an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SEGMENT = 2'd0,
        CMD_LOAD_GLYPH   = 2'd1,
        CMD_LOOKUP       = 2'd2
    } cmd_code_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_EVAL,
        S_GDATA,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_seg;
        logic load_glyph;
        logic start;
        logic walk;
        logic miss;
        logic check;
        logic eval;
        logic gdata;
        logic push;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic direct;
        logic out_free;
    } dp_status_t;

endpackage

[sv/cmap_format4_glyph_lookup_unit.sv]
// Top level of the cmap format 4 glyph lookup unit.
// Depends on cmap4_pkg, cmap4_ctrl, cmap4_dp and cmap4_ram.
//
// Usage: the input channel (in_valid/in_ready) carries one word per item:
// a segment load, a glyph array load or a code point lookup. Loads are
// written in the accepting cycle and give no output word. A lookup gives
// one output word (glyph_index, found) on the out_valid/out_ready channel.
// The segment count is set through cfg_we/cfg_wdata while the unit is idle.
//
// Sequence: a lookup walks the segment store one read per cycle, then
// checks and evaluates the glyph array position, reads the glyph array
// unless the mapping is direct, and pushes the result. One lookup is in
// flight at a time; the segment walk sets the throughput.
//
// Reset clears the controller, the output valid and sets the segment
// count to one. The stores are not cleared and must be loaded before use.
// When the receiver stalls, the result waits in the output register and
// the unit keeps taking loads and one further lookup, which then holds
// until the output register is free.
module cmap_format4_glyph_lookup_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cmap4_pkg::SEG_CNT_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cmap4_pkg::CMD_W-1:0]     command,
    input  logic [cmap4_pkg::SLOT_W-1:0]    slot,
    input  logic [cmap4_pkg::WORD_W-1:0]    end_code,
    input  logic [cmap4_pkg::WORD_W-1:0]    start_code,
    input  logic [cmap4_pkg::WORD_W-1:0]    id_delta,
    input  logic [cmap4_pkg::WORD_W-1:0]    range_offset,
    input  logic [cmap4_pkg::WORD_W-1:0]    glyph_word,
    input  logic [cmap4_pkg::WORD_W-1:0]    code_point,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cmap4_pkg::WORD_W-1:0]    glyph_index,
    output logic                            found
);
    import cmap4_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    // Controller.
    cmap4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath with the stores and the output register.
    cmap4_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .slot         (slot),
        .end_code     (end_code),
        .start_code   (start_code),
        .id_delta     (id_delta),
        .range_offset (range_offset),
        .glyph_word   (glyph_word),
        .code_point   (code_point),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .glyph_index  (glyph_index),
        .found        (found)
    );

endmodule

[sv/cmap4_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing; used for the segment and glyph array stores.
module cmap4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/cmap4_dp.sv]
// Datapath of the cmap format 4 lookup: stores, segment walk, position
// arithmetic and output register. Depends on cmap4_pkg and cmap4_ram.
module cmap4_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmap4_pkg::dp_cmd_t             cmd,
    output cmap4_pkg::dp_status_t          sts,
    input  logic                           cfg_we,
    input  logic [cmap4_pkg::SEG_CNT_W-1:0] cfg_wdata,
    input  logic [cmap4_pkg::SLOT_W-1:0]   slot,
    input  logic [cmap4_pkg::WORD_W-1:0]   end_code,
    input  logic [cmap4_pkg::WORD_W-1:0]   start_code,
    input  logic [cmap4_pkg::WORD_W-1:0]   id_delta,
    input  logic [cmap4_pkg::WORD_W-1:0]   range_offset,
    input  logic [cmap4_pkg::WORD_W-1:0]   glyph_word,
    input  logic [cmap4_pkg::WORD_W-1:0]   code_point,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [cmap4_pkg::WORD_W-1:0]   glyph_index,
    output logic                           found
);
    import cmap4_pkg::*;

    // Configuration and per-lookup registers.
    logic [SEG_CNT_W-1:0]  seg_cnt_reg, seg_cnt_next;
    logic [SEG_CNT_W-1:0]  used_reg, used_next;
    logic [WORD_W-1:0]     code_reg, code_next;
    logic [SEG_CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic                  pend_reg, pend_next;
    logic [SEG_ADDR_W-1:0] pend_seg_reg, pend_seg_next;
    logic [SEG_ADDR_W-1:0] hit_seg_reg, hit_seg_next;
    logic [WORD_W-1:0]     start_reg, start_next;
    logic [WORD_W-1:0]     delta_reg, delta_next;
    logic [WORD_W-1:0]     range_reg, range_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  bad_start_reg, bad_start_next;
    logic [WORD_W-1:0]     res_glyph_reg, res_glyph_next;
    logic                  res_found_reg, res_found_next;
    logic [WORD_W-1:0]     out_glyph_reg, out_glyph_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_valid_reg, out_valid_next;

    // Store ports.
    logic                  seg_we;
    logic                  glyph_we;
    logic                  issue;
    logic [SEG_RAM_W-1:0]  seg_wdata;
    logic [SEG_RAM_W-1:0]  seg_rdata;
    logic [WORD_W-1:0]     glyph_rdata;
    logic [WORD_W-1:0]     rd_end;
    logic [WORD_W-1:0]     rd_start;
    logic [WORD_W-1:0]     rd_delta;
    logic [WORD_W-1:0]     rd_range;
    logic                  pos_oob;
    logic                  miss_eval;

    // Loads are written in the cycle that they are accepted.
    assign seg_we = cmd.load_seg && (slot < SLOT_W'(MAX_SEGMENTS));
    assign glyph_we = cmd.load_glyph
        && ({1'b0, slot} < (SLOT_W + 1)'(GLYPH_ARRAY_DEPTH));
    assign seg_wdata = {end_code, start_code, id_delta, range_offset};

    // A segment read is issued every walk cycle until all segments are read.
    assign issue = cmd.walk && (issue_cnt_reg < used_reg);

    cmap4_ram #(
        .WIDTH (SEG_RAM_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (slot[SEG_ADDR_W-1:0]),
        .wdata (seg_wdata),
        .raddr (issue_cnt_reg[SEG_ADDR_W-1:0]),
        .rdata (seg_rdata)
    );

    cmap4_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GLYPH_ARRAY_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (glyph_we),
        .waddr (slot[GLYPH_ADDR_W-1:0]),
        .wdata (glyph_word),
        .raddr (pos_reg[GLYPH_ADDR_W-1:0]),
        .rdata (glyph_rdata)
    );

    assign {rd_end, rd_start, rd_delta, rd_range} = seg_rdata;

    // Position checks on the registered glyph array position.
    assign pos_oob = pos_reg[POS_W-1]
        || (pos_reg[POS_W-2:0] >= (POS_W - 1)'(GLYPH_ARRAY_DEPTH));
    assign miss_eval = bad_start_reg || ((range_reg != '0) && pos_oob);

    // Status towards the controller.
    always_comb
    begin
        sts.hit = pend_reg && (rd_end >= code_reg);
        sts.exhausted = !pend_reg && (issue_cnt_reg >= used_reg);
        sts.direct = bad_start_reg || (range_reg == '0) || pos_oob;
        sts.out_free = !out_valid_reg || out_ready;
    end

    // Next values of the configuration, walk and result registers.
    always_comb
    begin
        seg_cnt_next = seg_cnt_reg;
        used_next = used_reg;
        code_next = code_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next = issue;
        pend_seg_next = issue_cnt_reg[SEG_ADDR_W-1:0];
        hit_seg_next = hit_seg_reg;
        start_next = start_reg;
        delta_next = delta_reg;
        range_next = range_reg;
        pos_next = pos_reg;
        bad_start_next = bad_start_reg;
        res_glyph_next = res_glyph_reg;
        res_found_next = res_found_reg;
        out_glyph_next = out_glyph_reg;
        out_found_next = out_found_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            seg_cnt_next = cfg_wdata;
        end

        // A new lookup: clamp the segment count and restart the walk.
        if (cmd.start)
        begin
            code_next = code_point;
            issue_cnt_next = '0;
            if (seg_cnt_reg > SEG_CNT_W'(MAX_SEGMENTS))
            begin
                used_next = SEG_CNT_W'(MAX_SEGMENTS);
            end
            else
            begin
                used_next = seg_cnt_reg;
            end
        end

        if (issue)
        begin
            issue_cnt_next = issue_cnt_reg + SEG_CNT_W'(1);
        end

        // The first segment whose end reaches the code is kept.
        if (cmd.walk && sts.hit)
        begin
            hit_seg_next = pend_seg_reg;
            start_next = rd_start;
            delta_next = rd_delta;
            range_next = rd_range;
        end

        if (cmd.miss)
        begin
            res_glyph_next = '0;
            res_found_next = 1'b0;
        end

        // Glyph array position: range/2 + (code - start) - (used - segment).
        if (cmd.check)
        begin
            bad_start_next = start_reg > code_reg;
            pos_next = POS_W'(range_reg[WORD_W-1:1])
                + POS_W'(code_reg - start_reg)
                - POS_W'(used_reg - SEG_CNT_W'(hit_seg_reg));
        end

        // Results that need no glyph array read.
        if (cmd.eval && sts.direct)
        begin
            res_found_next = !miss_eval;
            res_glyph_next = miss_eval ? '0 : (delta_reg + code_reg);
        end

        // Results from the glyph array: a zero word stays zero.
        if (cmd.gdata)
        begin
            res_found_next = 1'b1;
            res_glyph_next = (glyph_rdata == '0) ? '0 : (glyph_rdata + delta_reg);
        end

        // Output register: a word leaves when the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_glyph_next = res_glyph_reg;
            out_found_next = res_found_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_cnt_reg <= SEG_CNT_RESET;
            used_reg <= '0;
            issue_cnt_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_cnt_reg <= seg_cnt_next;
            used_reg <= used_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        pend_seg_reg <= pend_seg_next;
        hit_seg_reg <= hit_seg_next;
        start_reg <= start_next;
        delta_reg <= delta_next;
        range_reg <= range_next;
        pos_reg <= pos_next;
        bad_start_reg <= bad_start_next;
        res_glyph_reg <= res_glyph_next;
        res_found_reg <= res_found_next;
        out_glyph_reg <= out_glyph_next;
        out_found_reg <= out_found_next;
    end

    assign out_valid = out_valid_reg;
    assign glyph_index = out_glyph_reg;
    assign found = out_found_reg;

    // The walk never reads past the segments in use.
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= used_reg)
        else $error("segment walk ran past the segment count");

    // A missing glyph is always reported as index zero.
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_glyph_reg == '0))
        else $error("missing glyph with non-zero index");

    // A new result is only pushed when the output register is free.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over an untaken word");

endmodule

[sv/cmap4_ctrl.sv]
// Controller state machine of the cmap format 4 lookup.
// Depends on cmap4_pkg; drives the command struct of cmap4_dp.
module cmap4_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [cmap4_pkg::CMD_W-1:0]  command,
    output logic                         in_ready,
    input  cmap4_pkg::dp_status_t        sts,
    output cmap4_pkg::dp_cmd_t           cmd
);
    import cmap4_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (command)
                        CMD_LOAD_SEGMENT:
                        begin
                            cmd.load_seg = 1'b1;
                        end
                        CMD_LOAD_GLYPH:
                        begin
                            cmd.load_glyph = 1'b1;
                        end
                        CMD_LOOKUP:
                        begin
                            cmd.start = 1'b1;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            // Unknown commands are dropped without a result.
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_CHECK;
                end
                else if (sts.exhausted)
                begin
                    cmd.miss = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = sts.direct ? S_DONE : S_GDATA;
            end
            S_GDATA:
            begin
                cmd.gdata = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An accepted lookup closes the input until its result is pushed.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_LOOKUP)) |=> !in_ready)
        else $error("input open during a lookup");

    // Every walk step that hits moves on to the position check.
    a_hit_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && sts.hit) |=> cmd.check)
        else $error("segment hit not followed by position check");

    // The glyph word is only taken right after a position evaluation.
    a_gdata_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gdata |-> $past(cmd.eval))
        else $error("glyph word taken without evaluation");

endmodule

[sim/tb_cmap_format4_glyph_lookup_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the cmap format 4 glyph lookup unit: a directed table,
// then random subtables and lookups at several segment counts, checked by a local predictor.
// Depends on cmap4_pkg and cmap_format4_glyph_lookup_unit.
module tb_cmap_format4_glyph_lookup_unit;
    import cmap4_pkg::*;

    localparam int DIR_ROWS = 25;
    localparam int N_PHASES = 9;
    localparam int DRAIN_CYCLES = 90;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam logic [WORD_W+1:0] NO_CHECK = '0;

    // One input word, one field per port.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] end_code;
        logic [WORD_W-1:0] start_code;
        logic [WORD_W-1:0] id_delta;
        logic [WORD_W-1:0] range_offset;
        logic [WORD_W-1:0] glyph_word;
        logic [WORD_W-1:0] code_point;
    } cmap_word_t;

    // A directed row, with the answer typed in where it is obvious.
    typedef struct packed {
        cmap_word_t        w;
        logic              has_answer;
        logic [WORD_W-1:0] glyph;
        logic              found;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [SEG_CNT_W-1:0] cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     command;
    logic [SLOT_W-1:0]    slot;
    logic [WORD_W-1:0]    end_code;
    logic [WORD_W-1:0]    start_code;
    logic [WORD_W-1:0]    id_delta;
    logic [WORD_W-1:0]    range_offset;
    logic [WORD_W-1:0]    glyph_word;
    logic [WORD_W-1:0]    code_point;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_W-1:0]    glyph_index;
    logic                 found;

    // Shadow copy of the subtable and the segment count.
    logic [SEG_CNT_W-1:0] model_seg_count;
    bit [WORD_W-1:0]      seg_end_m   [MAX_SEGMENTS];
    bit [WORD_W-1:0]      seg_start_m [MAX_SEGMENTS];
    bit [WORD_W-1:0]      seg_delta_m [MAX_SEGMENTS];
    bit [WORD_W-1:0]      seg_range_m [MAX_SEGMENTS];
    bit [WORD_W-1:0]      glyph_arr_m [GLYPH_ARRAY_DEPTH];
    bit                   seg_loaded   [MAX_SEGMENTS];
    bit                   glyph_loaded [GLYPH_ARRAY_DEPTH];

    // Lookup answers still owed by the unit, oldest first.
    logic [WORD_W-1:0]    pending_glyph_q [$];
    logic                 pending_found_q [$];

    int unsigned          mismatch_count;
    bit                   idling_on;
    bit                   hold_off_request;
    directed_row_t        dir_tbl [DIR_ROWS];
    int                   phase_counts [N_PHASES] = '{64, 0, 127, 1, 2, 65, 20, 9, 64};

    cmap_format4_glyph_lookup_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .slot         (slot),
        .end_code     (end_code),
        .start_code   (start_code),
        .id_delta     (id_delta),
        .range_offset (range_offset),
        .glyph_word   (glyph_word),
        .code_point   (code_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .glyph_index  (glyph_index),
        .found        (found)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic cmap_word_t make_word(input logic [CMD_W-1:0] cmd,
                                             input logic [SLOT_W-1:0] pos,
                                             input logic [WORD_W-1:0] e, s, d, r, gw, cp);
        cmap_word_t w;
        w = {cmd, pos, e, s, d, r, gw, cp};
        return w;
    endfunction

    // Every field random, so that unused fields are exercised too.
    function automatic cmap_word_t random_word();
        cmap_word_t w;
        w.command      = CMD_W'($urandom);
        w.slot         = SLOT_W'($urandom);
        w.end_code     = WORD_W'($urandom);
        w.start_code   = WORD_W'($urandom);
        w.id_delta     = WORD_W'($urandom);
        w.range_offset = WORD_W'($urandom);
        w.glyph_word   = WORD_W'($urandom);
        w.code_point   = WORD_W'($urandom);
        return w;
    endfunction

    function automatic int effective_segments();
        return (model_seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(model_seg_count);
    endfunction

    // Maps a code point through the shadow subtable. The safe flag drops when the
    // lookup would touch an entry that has never been loaded.
    task automatic resolve_code_point(input logic [WORD_W-1:0] code,
                                      output logic [WORD_W-1:0] glyph,
                                      output logic hit, output bit safe);
        int used;
        int hit_seg;
        int pos;
        bit [WORD_W-1:0] word;
        used = effective_segments();
        glyph = '0;
        hit = 1'b0;
        safe = 1'b1;
        hit_seg = -1;
        // The first segment whose end code reaches the code point wins.
        for (int seg = 0; seg < used; seg++)
        begin
            if (hit_seg < 0)
            begin
                if (!seg_loaded[seg])
                    safe = 1'b0;
                if (seg_end_m[seg] >= code)
                    hit_seg = seg;
            end
        end
        if (hit_seg >= 0 && seg_start_m[hit_seg] <= code)
        begin
            if (seg_range_m[hit_seg] == 0)
            begin
                glyph = seg_delta_m[hit_seg] + code;
                hit = 1'b1;
            end
            else
            begin
                pos = int'(seg_range_m[hit_seg] >> 1) + int'(code)
                      - int'(seg_start_m[hit_seg]) - (used - hit_seg);
                if (pos >= 0 && pos < GLYPH_ARRAY_DEPTH)
                begin
                    if (!glyph_loaded[pos])
                        safe = 1'b0;
                    word = glyph_arr_m[pos];
                    glyph = (word == 0) ? WORD_W'(0) : WORD_W'(word + seg_delta_m[hit_seg]);
                    hit = 1'b1;
                end
            end
        end
    endtask

    // Updates the shadow state for an accepted word and queues any answer it owes.
    task automatic track_word(input cmap_word_t w);
        logic [WORD_W-1:0] g;
        logic f;
        bit ok;
        case (w.command)
            CMD_LOAD_SEGMENT:
                if (w.slot < MAX_SEGMENTS)
                begin
                    seg_end_m[w.slot]   = w.end_code;
                    seg_start_m[w.slot] = w.start_code;
                    seg_delta_m[w.slot] = w.id_delta;
                    seg_range_m[w.slot] = w.range_offset;
                    seg_loaded[w.slot]  = 1'b1;
                end
            CMD_LOAD_GLYPH:
                if (w.slot < GLYPH_ARRAY_DEPTH)
                begin
                    glyph_arr_m[w.slot]  = w.glyph_word;
                    glyph_loaded[w.slot] = 1'b1;
                end
            CMD_LOOKUP:
            begin
                resolve_code_point(w.code_point, g, f, ok);
                pending_glyph_q.push_back(g);
                pending_found_q.push_back(f);
            end
            default:
                ;
        endcase
    endtask

    // Offers one word, possibly after a short gap, and returns at the accepting edge.
    task automatic send_word(input cmap_word_t w);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= w.command;
        slot         <= w.slot;
        end_code     <= w.end_code;
        start_code   <= w.start_code;
        id_delta     <= w.id_delta;
        range_offset <= w.range_offset;
        glyph_word   <= w.glyph_word;
        code_point   <= w.code_point;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic issue(input cmap_word_t w);
        send_word(w);
        track_word(w);
    endtask

    task automatic load_segment(input int pos, input logic [WORD_W-1:0] e, s, d, r);
        cmap_word_t w;
        w = random_word();
        w.command = CMD_LOAD_SEGMENT;
        w.slot = SLOT_W'(pos);
        w.end_code = e;
        w.start_code = s;
        w.id_delta = d;
        w.range_offset = r;
        issue(w);
    endtask

    task automatic load_glyph(input int pos, input logic [WORD_W-1:0] value);
        cmap_word_t w;
        w = random_word();
        w.command = CMD_LOAD_GLYPH;
        w.slot = SLOT_W'(pos);
        w.glyph_word = value;
        issue(w);
    endtask

    // A lookup is only sent when it reads nothing that was never loaded.
    task automatic try_lookup(input logic [WORD_W-1:0] code);
        cmap_word_t w;
        logic [WORD_W-1:0] g;
        logic f;
        bit ok;
        resolve_code_point(code, g, f, ok);
        if (ok)
        begin
            w = random_word();
            w.command = CMD_LOOKUP;
            w.code_point = code;
            issue(w);
        end
    endtask

    // Stops offering words, waits for every answer and lets the unit settle.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_found_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Builds a sorted subtable: each segment sits in its own slice of the code space,
    // some map by delta, the others through a short run of glyph array words.
    task automatic build_table(input int used);
        int width;
        int lo;
        int hi;
        int len;
        int base_pos;
        int off;
        logic [WORD_W-1:0] r;
        width = 65536 / used;
        for (int k = 0; k < used; k++)
        begin
            lo = k * width + int'($urandom_range(0, width / 4));
            if ($urandom_range(0, 2) == 0)
            begin
                len = $urandom_range(0, (width / 2 < 15) ? width / 2 : 15);
                hi = lo + len;
                // Runs may hang off either end of the glyph array on purpose.
                base_pos = int'($urandom_range(0, GLYPH_ARRAY_DEPTH + 16)) - 2;
                off = base_pos + used - k;
                r = (off > 0) ? WORD_W'(2 * off + int'($urandom_range(0, 1))) : WORD_W'(1);
                for (int p = base_pos; p <= base_pos + len; p++)
                begin
                    if (p >= 0 && p < GLYPH_ARRAY_DEPTH)
                        load_glyph(p, ($urandom_range(0, 4) == 0) ? WORD_W'(0)
                                                                   : WORD_W'($urandom));
                end
            end
            else
            begin
                hi = lo + int'($urandom_range(0, width / 2));
                r = '0;
            end
            // Now and then a broken segment that starts past its end.
            if ($urandom_range(0, 15) == 0 && hi < 16'hFFFF)
                lo = hi + 1;
            // The usual terminating segment at the top of the code space.
            if (k == used - 1 && $urandom_range(0, 1) == 0)
            begin
                lo = 16'hFFFF;
                hi = 16'hFFFF;
                r = '0;
            end
            load_segment(k, WORD_W'(hi), WORD_W'(lo), WORD_W'($urandom), r);
        end
    endtask

    // Mostly lookups inside known segments, with loads, stray codes and ignored words.
    task automatic run_mix(input int n_words);
        int used;
        int pick;
        int k;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        cmap_word_t w;
        used = effective_segments();
        for (int i = 0; i < n_words; i++)
        begin
            pick = $urandom_range(0, 99);
            k = (used > 0) ? int'($urandom_range(0, used - 1)) : 0;
            lo = seg_start_m[k];
            hi = seg_end_m[k];
            if (pick < 68 && used > 0)
                try_lookup((lo <= hi) ? WORD_W'(lo + $urandom_range(0, hi - lo)) : hi);
            else if (pick < 80)
            begin
                case ($urandom_range(0, 4))
                    0: try_lookup(lo - 1'b1);
                    1: try_lookup(hi + 1'b1);
                    2: try_lookup('0);
                    3: try_lookup('1);
                    default: try_lookup(WORD_W'($urandom));
                endcase
            end
            else if (pick < 90)
                load_glyph($urandom_range(0, GLYPH_ARRAY_DEPTH - 1), WORD_W'($urandom));
            else if (pick < 96)
                load_segment(($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 1023))
                                                         : int'($urandom_range(0, 63)),
                             WORD_W'($urandom), WORD_W'($urandom),
                             WORD_W'($urandom), WORD_W'($urandom));
            else
            begin
                w = random_word();
                w.command = CMD_IGNORED;
                issue(w);
            end
        end
    endtask

    // Stimulus: reset, directed table, then one phase per segment count.
    initial
    begin
        dir_tbl[0]  = {make_word(CMD_LOAD_SEGMENT, 0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[1]  = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b1, 16'h0000, 1'b1};
        dir_tbl[2]  = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1, 16'hFFFF, 1'b1};
        dir_tbl[3]  = {make_word(CMD_LOAD_SEGMENT, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[4]  = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0001), 1'b1, 16'h0000, 1'b1};
        dir_tbl[5]  = {make_word(CMD_LOAD_SEGMENT, 0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[6]  = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h8000), 1'b1, 16'h0000, 1'b0};
        dir_tbl[7]  = {make_word(CMD_LOAD_SEGMENT, 0, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[8]  = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h7FFF), 1'b1, 16'h0000, 1'b0};
        dir_tbl[9]  = {make_word(CMD_LOAD_SEGMENT, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF), NO_CHECK};
        dir_tbl[10] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h8000), 1'b1, 16'h8000, 1'b1};
        dir_tbl[11] = {make_word(CMD_IGNORED, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF), NO_CHECK};
        dir_tbl[12] = {make_word(CMD_LOAD_GLYPH, 10'h000, 0, 0, 0, 0, 16'h0000, 0), NO_CHECK};
        dir_tbl[13] = {make_word(CMD_LOAD_GLYPH, 10'h3FF, 0, 0, 0, 0, 16'hFFFF, 0), NO_CHECK};
        dir_tbl[14] = {make_word(CMD_LOAD_GLYPH, 10'h001, 0, 0, 0, 0, 16'h1234, 0), NO_CHECK};
        dir_tbl[15] = {make_word(CMD_LOAD_SEGMENT, 0, 16'hFFFF, 16'h0000, 16'h0005, 16'h0002,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[16] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b1, 16'h0000, 1'b1};
        dir_tbl[17] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h03FF), 1'b1, 16'h0004, 1'b1};
        dir_tbl[18] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0001), NO_CHECK};
        dir_tbl[19] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0400), 1'b1, 16'h0000, 1'b0};
        dir_tbl[20] = {make_word(CMD_LOAD_SEGMENT, 0, 16'hFFFF, 16'h0010, 16'h0000, 16'h0001,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[21] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0010), 1'b1, 16'h0000, 1'b0};
        dir_tbl[22] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0011), NO_CHECK};
        dir_tbl[23] = {make_word(CMD_LOAD_SEGMENT, 0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                                 16'h0, 16'h0), NO_CHECK};
        dir_tbl[24] = {make_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b1, 16'h0000, 1'b0};

        model_seg_count = SEG_CNT_RESET;
        mismatch_count = 0;
        idling_on = 1'b1;
        hold_off_request = 1'b0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        command      <= '0;
        slot         <= '0;
        end_code     <= '0;
        start_code   <= '0;
        id_delta     <= '0;
        range_offset <= '0;
        glyph_word   <= '0;
        code_point   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run at the reset segment count of one.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_word(dir_tbl[i].w);
            if (dir_tbl[i].has_answer)
            begin
                pending_glyph_q.push_back(dir_tbl[i].glyph);
                pending_found_q.push_back(dir_tbl[i].found);
            end
            else
                track_word(dir_tbl[i].w);
        end

        // Each phase sets a new count while idle, loads a subtable unless the count is zero, and runs the mix.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_until_idle();
            idling_on = (ph != N_PHASES - 1);
            cfg_we <= 1'b1;
            cfg_wdata <= SEG_CNT_W'(phase_counts[ph]);
            @(posedge clk);
            cfg_we <= 1'b0;
            model_seg_count = SEG_CNT_W'(phase_counts[ph]);
            if (effective_segments() > 0)
                build_table(effective_segments());
            if (ph == 0)
                hold_off_request = 1'b1;
            run_mix((phase_counts[ph] == 0) ? 20 : 100);
        end

        wait_until_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off that fills the unit.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Each accepted output word is compared with the oldest answer owed.
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want_glyph;
        logic want_found;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_found_q.size() == 0)
            begin
                $error("Output word with no lookup outstanding: glyph_index %h found %b",
                       glyph_index, found);
                mismatch_count++;
            end
            else
            begin
                want_glyph = pending_glyph_q.pop_front();
                want_found = pending_found_q.pop_front();
                if (found !== want_found)
                begin
                    $error("found: expected %b, actual %b", want_found, found);
                    mismatch_count++;
                end
                if (glyph_index !== want_glyph)
                begin
                    $error("glyph_index: expected %h, actual %h", want_glyph, glyph_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Safety net against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
